FILE: rtl/udph_pkg.sv
// ----------------------------------------------------------------------------
// udph_pkg
// Shared types and register codes for the UDP header builder.
// ----------------------------------------------------------------------------

package udph_pkg;

   // configuration register map
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrSourcePort     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrDestPort       = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrChecksumEnable = 2'd2;

   localparam int CsrDataWidth = 16;

   // packet byte counter saturates here
   localparam logic [16:0] CountMax    = 17'h1FFFF;
   localparam logic [17:0] HeaderBytes = 18'd8;

   // one payload byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // one header result
   typedef struct packed {
      logic [15:0] out_src_port;
      logic [15:0] out_dst_port;
      logic [15:0] udp_length;
      logic [15:0] udp_checksum;
      logic        length_error;
   } rsp_type;

   // configuration as seen by the checksum core
   typedef struct packed {
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic        checksum_enable;
   } cfg_type;

endpackage

FILE: rtl/udph_core.sv
// ----------------------------------------------------------------------------
// udph_core
// Per-packet byte count and ones-complement sum, and the header result that
// is formed on the final byte of a packet.
// ----------------------------------------------------------------------------

module udph_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  udph_pkg::req_type item,
   input  udph_pkg::cfg_type cfg,
   output udph_pkg::rsp_type result
);

   // packet state
   logic [15:0] sum_ff,  sum_in;
   logic [16:0] cnt_ff,  cnt_in;
   logic [7:0]  held_ff, held_in;
   logic        odd_ff,  odd_in;

   logic [15:0] pair_word;
   logic [16:0] cnt_inc;
   logic [17:0] total;
   logic        len_err;
   logic [15:0] len;
   logic [16:0] pair_sum;
   logic [18:0] wide_sum;
   logic [15:0] folded;

   // end-around fold of a sum of up to eight 16-bit words
   function automatic logic [15:0] fold19(input logic [18:0] s);
      logic [16:0] f1;
      logic [15:0] f2;
      f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
      f2 = f1[15:0] + {15'b0, f1[16]};
      return f2;
   endfunction

   // word completed by this byte, or the final odd byte padded with zero
   assign pair_word = odd_ff ? {held_ff, item.data_byte} : {item.data_byte, 8'h00};

   // saturating count and header length
   assign cnt_inc = (cnt_ff == udph_pkg::CountMax) ? cnt_ff : cnt_ff + 17'd1;
   assign total   = {1'b0, cnt_inc} + udph_pkg::HeaderBytes;
   assign len_err = |total[17:16];
   assign len     = len_err ? 16'hFFFF : total[15:0];

   // running sum plus the new word, folded back to 16 bits
   assign pair_sum = {1'b0, sum_ff} + {1'b0, pair_word};

   // whole checksum: payload, ports and length in one multi-operand add
   assign wide_sum = {3'b0, sum_ff} + {3'b0, pair_word} + {3'b0, cfg.source_port}
                   + {3'b0, cfg.dest_port} + {3'b0, len};
   assign folded   = fold19(wide_sum);

   // header result, only used on the final byte
   always_comb begin
      result.out_src_port = cfg.source_port;
      result.out_dst_port = cfg.dest_port;
      result.udp_length   = len;
      result.udp_checksum = cfg.checksum_enable ? ~folded : 16'h0000;
      result.length_error = len_err;
   end

   // state update per byte transfer
   always_comb begin
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      held_in = held_ff;
      odd_in  = odd_ff;
      if (step) begin
         if (item.last_byte) begin
            sum_in  = 16'h0000;
            cnt_in  = 17'd0;
            held_in = 8'h00;
            odd_in  = 1'b0;
         end else begin
            cnt_in = cnt_inc;
            if (odd_ff) begin
               sum_in  = pair_sum[15:0] + {15'b0, pair_sum[16]};
               held_in = 8'h00;
               odd_in  = 1'b0;
            end else begin
               held_in = item.data_byte;
               odd_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= 16'h0000;
         cnt_ff  <= 17'd0;
         held_ff <= 8'h00;
         odd_ff  <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
         odd_ff  <= odd_in;
      end
   end

   // a held byte is always cleared when no byte is pending
   a_held_clear: assert property (@(posedge clock) disable iff (reset)
      !odd_ff |-> held_ff == 8'h00)
      else $error("held byte set with no pending byte");

   // a final byte leaves the packet state empty
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> cnt_ff == 17'd0 && sum_ff == 16'h0000 && !odd_ff)
      else $error("packet state not cleared after final byte");

   // the running sum only moves on a byte transfer
   a_sum_stable: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(sum_ff) && $stable(cnt_ff))
      else $error("packet state changed without a transfer");

endmodule

FILE: rtl/udp_header_builder_top.sv
// The header appears on rsp_ once a packet's final byte has passed the input stage and then the result register.
// Throughput: one payload byte per cycle, back to back, set by the single input stage, while the input is not stalled.
// A waiting header stalls the input only when another final byte needs the result register.
// Reset (synchronous): clears the packet state and both stages; source and destination
// ports return to zero and checksums are enabled.
// ----------------------------------------------------------------------------
// udp_header_builder_top
// Builds the 8-byte UDP header for a packet from its payload byte stream.
// ----------------------------------------------------------------------------

module udp_header_builder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // payload byte channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  udph_pkg::req_type                     req_payload,
   // header result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output udph_pkg::rsp_type                     rsp_payload,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [udph_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [udph_pkg::CsrDataWidth-1:0]     csr_wdata
);

   // configuration registers
   udph_pkg::cfg_type cfg_ff, cfg_in;

   // input stage
   logic              in_valid_ff, in_valid_in;
   udph_pkg::req_type in_item_ff, in_item_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   udph_pkg::rsp_type out_data_ff, out_data_in;

   logic              req_xfer;
   logic              out_free;
   logic              advance;
   udph_pkg::rsp_type core_result;

   assign csr_ready = 1'b1;

   // register writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            udph_pkg::CsrSourcePort:     cfg_in.source_port     = csr_wdata;
            udph_pkg::CsrDestPort:       cfg_in.dest_port       = csr_wdata;
            udph_pkg::CsrChecksumEnable: cfg_in.checksum_enable = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   // stage handshake: only a final byte needs room in the result register
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_item_ff.last_byte || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_item_in  = req_payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   udph_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // result register load and drain
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance && in_item_ff.last_byte) begin
         out_valid_in = 1'b1;
         out_data_in  = core_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_port     <= 16'h0000;
         cfg_ff.dest_port       <= 16'h0000;
         cfg_ff.checksum_enable <= 1'b1;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   // a new header only follows a final byte leaving the input stage
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && in_item_ff.last_byte))
      else $error("header produced without a final byte");

   // the input stalls only behind a blocked final byte
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_item_ff.last_byte && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked header");

   // an oversize flag always comes with a saturated length
   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.length_error |-> out_data_ff.udp_length == 16'hFFFF)
      else $error("length error without saturated length");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UDP header builder. Payload bytes are offered
// under several idling mixes and register settings, each header is predicted
// from a local ones-complement model and compared field by field.
// ----------------------------------------------------------------------------

module tb_top;

   localparam logic [udph_pkg::CsrIndexWidth-1:0] CsrUnused = 2'd3;
   localparam int LimitCycles = 3_000_000;
   localparam int HoldCycles  = 300;
   localparam int DrainCycles = 8;
   localparam int PhaseItems  = 160;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_stall;
   udph_pkg::req_type                  req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_stall   = 1'b0;
   udph_pkg::rsp_type                  rsp_payload;
   logic                               csr_valid   = 1'b0;
   logic                               csr_ready;
   logic [udph_pkg::CsrIndexWidth-1:0] csr_index   = '0;
   logic [udph_pkg::CsrDataWidth-1:0]  csr_wdata   = '0;

   // idling mix in percent, long receiver hold-off request
   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   logic        hold_req  = 1'b0;
   logic        hold_ack  = 1'b0;
   int unsigned hold_left = 0;
   int unsigned fail_count = 0;

   // register copies, as after reset
   logic [15:0] cfg_src_port = 16'h0000;
   logic [15:0] cfg_dst_port = 16'h0000;
   logic        cfg_cks_en   = 1'b1;

   // packet state of the header model
   logic [15:0] pkt_sum   = '0;
   logic [16:0] pkt_count = '0;
   logic [7:0]  pkt_high  = '0;
   logic        pkt_odd   = 1'b0;

   // headers still to arrive, oldest first
   udph_pkg::rsp_type header_q[$];
   udph_pkg::rsp_type header_want;

   udp_header_builder_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // end-around-carry add of two 16-bit words
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // fold one accepted byte into the packet state, build the header on the last
   function automatic void track_byte(input udph_pkg::req_type item);
      logic [15:0]       sum;
      logic [17:0]       total;
      udph_pkg::rsp_type hdr;
      if (pkt_count != udph_pkg::CountMax) pkt_count = pkt_count + 17'd1;
      if (pkt_odd) begin
         pkt_sum  = ones_add(pkt_sum, {pkt_high, item.data_byte});
         pkt_high = '0;
         pkt_odd  = 1'b0;
      end else begin
         pkt_high = item.data_byte;
         pkt_odd  = 1'b1;
      end
      if (item.last_byte) begin
         sum = pkt_sum;
         if (pkt_odd) sum = ones_add(sum, {pkt_high, 8'h00});
         total = {1'b0, pkt_count} + udph_pkg::HeaderBytes;
         hdr.length_error = (total > 18'h0FFFF);
         hdr.udp_length   = hdr.length_error ? 16'hFFFF : total[15:0];
         sum = ones_add(sum, cfg_src_port);
         sum = ones_add(sum, cfg_dst_port);
         sum = ones_add(sum, hdr.udp_length);
         hdr.udp_checksum = cfg_cks_en ? ~sum : 16'h0000;
         hdr.out_src_port = cfg_src_port;
         hdr.out_dst_port = cfg_dst_port;
         header_q.push_back(hdr);
         pkt_sum   = '0;
         pkt_count = '0;
         pkt_high  = '0;
         pkt_odd   = 1'b0;
      end
   endfunction

   // offer one byte after a random gap, return at its transfer
   task automatic send_byte(input logic [7:0] data, input logic last);
      udph_pkg::req_type item;
      item.data_byte = data;
      item.last_byte = last;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_byte(item);
   endtask

   task automatic send_packet(input int unsigned len);
      int unsigned i;
      for (i = 1; i <= len; i++) send_byte(8'($urandom), i == len);
   endtask

   // drop valid and let every outstanding header drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (header_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // one register write transfer; valid is left high for the caller
   task automatic csr_put(input logic [udph_pkg::CsrIndexWidth-1:0] index,
                          input logic [udph_pkg::CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         udph_pkg::CsrSourcePort:     cfg_src_port = data;
         udph_pkg::CsrDestPort:       cfg_dst_port = data;
         udph_pkg::CsrChecksumEnable: cfg_cks_en   = data[0];
         default: ;
      endcase
   endtask

   // full register set, plus a write to the unmapped index that must be ignored
   task automatic set_config(input logic [15:0] src, input logic [15:0] dst, input logic en);
      wait_idle();
      csr_put(CsrUnused, 16'($urandom));
      csr_put(udph_pkg::CsrSourcePort, src);
      csr_put(udph_pkg::CsrDestPort, dst);
      csr_put(udph_pkg::CsrChecksumEnable, {15'($urandom), en});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_port();
      case ($urandom_range(3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly short packets, now and then a longer one
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(8, 1);
      if (r < 95) return $urandom_range(40, 9);
      return $urandom_range(120, 41);
   endfunction

   // header registers straight out of reset, odd single-byte packets
   task automatic test_reset_defaults();
      send_byte(8'hA5, 1'b1);
      send_byte(8'h00, 1'b1);
   endtask

   // checksum that comes out as zero, carry folding, lone all-ones byte
   task automatic test_checksum_cases();
      set_config(16'h0000, 16'h0000, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF5, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b1);
   endtask

   // port extremes with checksum on and off
   task automatic test_port_extremes();
      set_config(16'hFFFF, 16'hFFFF, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFE, 1'b1);
      set_config(16'hFFFF, 16'h0000, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      set_config(16'h0000, 16'hFFFF, 1'b1);
      send_byte(8'h5A, 1'b1);
   endtask

   // registers rewritten between bytes of one packet take effect on its last byte
   task automatic test_config_mid_packet();
      set_config(16'h1234, 16'hABCD, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC3, 1'b0);
      set_config(16'h8000, 16'h0001, 1'b1);
      send_byte(8'h7E, 1'b1);
   endtask

   // receiver holds off for a long stretch while short packets keep coming
   task automatic test_back_pressure();
      int unsigned n;
      set_config(pick_port(), pick_port(), 1'b1);
      hold_req <= ~hold_req;
      for (n = 0; n < 40; n++) send_packet($urandom_range(3, 1));
   endtask

   // random packets under each idling mix, registers changed halfway
   task automatic test_random_traffic();
      int unsigned gap_mix[4]   = '{0, 68, 0, 19};
      int unsigned stall_mix[4] = '{0, 0, 68, 19};
      int unsigned p;
      int unsigned sent;
      int unsigned len;
      logic        reconfigured;
      for (p = 0; p < 4; p++) begin
         gap_pct   = gap_mix[p];
         stall_pct = stall_mix[p];
         set_config(pick_port(), pick_port(), $urandom_range(3) != 0);
         sent = 0;
         reconfigured = 1'b0;
         while (sent < PhaseItems) begin
            if (!reconfigured && sent >= PhaseItems / 2) begin
               set_config(pick_port(), pick_port(), $urandom_range(3) != 0);
               reconfigured = 1'b1;
            end
            len = pick_length();
            send_packet(len);
            sent = sent + len;
         end
      end
   endtask

   // receiver stall: random mix, or a counted hold-off when requested
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // compare every header transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (header_q.size() == 0) begin
            $error("header transfer with no packet outstanding");
            fail_count++;
         end else begin
            header_want = header_q.pop_front();
            check_field("out_src_port", header_want.out_src_port, rsp_payload.out_src_port);
            check_field("out_dst_port", header_want.out_dst_port, rsp_payload.out_dst_port);
            check_field("udp_length", header_want.udp_length, rsp_payload.udp_length);
            check_field("udp_checksum", header_want.udp_checksum, rsp_payload.udp_checksum);
            check_field("length_error", {15'd0, header_want.length_error},
                        {15'd0, rsp_payload.length_error});
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_checksum_cases();
      test_port_extremes();
      test_config_mid_packet();
      test_back_pressure();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #(LimitCycles * 10);
      $display("tb: failure");
      $finish;
   end

endmodule
